>>> hdl/dtc_pkg.sv
package dtc_pkg;

    // Fixed field widths of the command port
    localparam int CMD_W     = 3;
    localparam int NODE_ID_W = 11;
    localparam int SPLIT_W   = 6;
    localparam int CLUSTER_W = 16;
    localparam int QCOUNT_W  = 4;
    localparam int QSLOT_W   = 3;
    localparam int AIDX_W    = 6;
    localparam int CATVAL_W  = 16;

    // Parameter defaults
    localparam int TREE_LEVELS_DEF   = 11;
    localparam int NUM_ATTRS_DEF     = 64;
    localparam int MAX_QUESTIONS_DEF = 8;
    localparam int CATEGORY_BITS_DEF = 16;

    // Cluster reported on a failed walk
    localparam logic signed [CLUSTER_W-1:0] CLUSTER_NONE = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_NODE     = 3'd0,
        CMD_LOAD_QUESTION = 3'd1,
        CMD_LOAD_ATTR     = 3'd2,
        CMD_CLASSIFY      = 3'd3,
        CMD_CLEAR         = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ROOT,
        ST_READ,
        ST_EVAL
    } t_state;

    // One node table word; the count is saturated and never exceeds 15
    typedef struct packed {
        logic                        present;
        logic [SPLIT_W-1:0]          split;
        logic signed [CLUSTER_W-1:0] cluster;
        logic [QCOUNT_W-1:0]         qcount;
    } t_node;

endpackage

>>> hdl/dtc_qmatch.sv
module dtc_qmatch
    import dtc_pkg::*;
#(
    parameter int TREE_LEVELS   = TREE_LEVELS_DEF,
    parameter int MAX_QUESTIONS = MAX_QUESTIONS_DEF,
    parameter int CATEGORY_BITS = CATEGORY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [TREE_LEVELS:0]     i_wr_addr,
    input  logic [QSLOT_W-1:0]       i_wr_slot,
    input  logic [CATEGORY_BITS-1:0] i_wr_data,
    input  logic [TREE_LEVELS:0]     i_rd_addr,
    input  logic [CATEGORY_BITS-1:0] i_attr_value,
    input  logic [QCOUNT_W-1:0]      i_count,
    output logic                     o_match
);

    localparam int DEPTH = 2 ** (TREE_LEVELS + 1);

    logic [MAX_QUESTIONS-1:0] hit;

    // One memory lane per question slot, all read at the same node address
    for (genvar g = 0; g < MAX_QUESTIONS; g++) begin : g_lane
        logic [CATEGORY_BITS-1:0] mem [DEPTH];
        logic [CATEGORY_BITS-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_wr_en && (32'(i_wr_slot) == g)) begin
                mem[i_wr_addr] <= i_wr_data;
            end
            r_q <= mem[i_rd_addr];
        end

        // slot counts only when it lies inside the node's question set
        assign hit[g] = (32'(i_count) > g) && (r_q == i_attr_value);
    end

    assign o_match = |hit;

endmodule

>>> hdl/decision_tree_classify.sv
// Channel   Direction  Handshake                   Fields
// command   in         start high while busy low   i_command .. i_category_value
// result    out        o_result_valid, 1 cycle     o_leaf_cluster, o_walk_error
//
// Loads leave busy low. Classify: a root check, then per node visited a read
// state and a compare state (node read of both children, then compare); the
// result strobe comes in the same cycle that busy drops.
// Clear tree: a sweep of the selected tree's entries; busy is high meanwhile.
// Reset: a sweep over the whole table clears the present bits; busy is
// high meanwhile. The receiver cannot stall: each result shows for one cycle.
module decision_tree_classify
    import dtc_pkg::*;
#(
    parameter int TREE_LEVELS   = TREE_LEVELS_DEF,
    parameter int NUM_ATTRS     = NUM_ATTRS_DEF,
    parameter int MAX_QUESTIONS = MAX_QUESTIONS_DEF,
    parameter int CATEGORY_BITS = CATEGORY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [CMD_W-1:0]            i_command,
    input  logic                        i_tree_select,
    input  logic [NODE_ID_W-1:0]        i_node_id,
    input  logic [SPLIT_W-1:0]          i_split_attr,
    input  logic signed [CLUSTER_W-1:0] i_node_cluster,
    input  logic [QCOUNT_W-1:0]         i_question_count,
    input  logic [QSLOT_W-1:0]          i_question_slot,
    input  logic [AIDX_W-1:0]           i_attr_index,
    input  logic [CATVAL_W-1:0]         i_category_value,
    output logic                        o_result_valid,
    output logic signed [CLUSTER_W-1:0] o_leaf_cluster,
    output logic                        o_walk_error
);

    localparam int NODE_AW    = TREE_LEVELS + 1;
    localparam int NODE_DEPTH = 2 ** NODE_AW;
    localparam int AI_W       = $clog2(NUM_ATTRS);
    localparam logic [TREE_LEVELS-1:0] ROOT_ID = 1;

    // Control registers
    t_state                 r_state, n_state;
    logic                   r_tree, n_tree;
    logic [TREE_LEVELS-1:0] r_node, n_node;
    t_node                  r_cur, n_cur;
    logic [NODE_AW-1:0]     r_sweep, n_sweep;
    logic                   r_sweep_all, n_sweep_all;
    logic                   r_out_valid, n_out_valid;
    logic signed [CLUSTER_W-1:0] r_out_cluster, n_out_cluster;
    logic                   r_out_error, n_out_error;

    // Node table: one write port, two read ports
    t_node                  node_mem [NODE_DEPTH];
    t_node                  r_rd_a, r_rd_b;
    logic                   node_we;
    logic [NODE_AW-1:0]     node_waddr;
    t_node                  node_wdata;
    logic [NODE_AW-1:0]     rd_addr_a, rd_addr_b;

    // Attribute vector
    logic [CATEGORY_BITS-1:0] attr_mem [NUM_ATTRS];
    logic [CATEGORY_BITS-1:0] r_attr_q;
    logic                     attr_we;

    logic accept;
    logic q_we;
    logic q_match;
    logic nid_ok, slot_ok, aidx_ok, split_ok;
    logic [TREE_LEVELS-1:0] nid_l;
    logic [TREE_LEVELS+NODE_ID_W-1:0] nid_ext;
    logic [AI_W-1:0]        attr_waddr, attr_raddr;
    logic [AI_W+AIDX_W-1:0] aidx_ext;
    logic [AI_W+SPLIT_W-1:0] split_ext;
    logic [31:0]            cat_ext;
    logic [QCOUNT_W-1:0]    qcount_sat;
    logic                   sweep_end;
    logic                   left_oob;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Range checks and width adaptation of the command fields
    assign nid_ext    = {{TREE_LEVELS{1'b0}}, i_node_id};
    assign nid_l      = nid_ext[TREE_LEVELS-1:0];
    assign nid_ok     = (i_node_id >> TREE_LEVELS) == '0;
    assign slot_ok    = 32'(i_question_slot) < MAX_QUESTIONS;
    assign aidx_ok    = 32'(i_attr_index) < NUM_ATTRS;
    assign aidx_ext   = {{AI_W{1'b0}}, i_attr_index};
    assign attr_waddr = aidx_ext[AI_W-1:0];
    assign split_ext  = {{AI_W{1'b0}}, r_cur.split};
    assign attr_raddr = split_ext[AI_W-1:0];
    assign split_ok   = 32'(r_cur.split) < NUM_ATTRS;
    assign cat_ext    = {{(32-CATVAL_W){1'b0}}, i_category_value};
    assign qcount_sat = (32'(i_question_count) > MAX_QUESTIONS) ?
                        QCOUNT_W'(MAX_QUESTIONS) : i_question_count;

    // Leaves sit on the last level: children would fall past the table
    assign left_oob  = r_node[TREE_LEVELS-1];
    assign sweep_end = r_sweep_all ? (&r_sweep) : (&r_sweep[TREE_LEVELS-1:0]);

    // Port A fetches the root at accept, then the left child; port B the right
    assign rd_addr_a = (r_state == ST_IDLE) ? {i_tree_select, ROOT_ID}
                                            : {r_tree, r_node[TREE_LEVELS-2:0], 1'b0};
    assign rd_addr_b = {r_tree, r_node[TREE_LEVELS-2:0], 1'b1};

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_rd_a <= node_mem[rd_addr_a];
        r_rd_b <= node_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            attr_mem[attr_waddr] <= cat_ext[CATEGORY_BITS-1:0];
        end
        r_attr_q <= attr_mem[attr_raddr];
    end

    dtc_qmatch #(
        .TREE_LEVELS   (TREE_LEVELS),
        .MAX_QUESTIONS (MAX_QUESTIONS),
        .CATEGORY_BITS (CATEGORY_BITS)
    ) u_qmatch (
        .i_clk        (i_clk),
        .i_wr_en      (q_we),
        .i_wr_addr    ({i_tree_select, nid_l}),
        .i_wr_slot    (i_question_slot),
        .i_wr_data    (cat_ext[CATEGORY_BITS-1:0]),
        .i_rd_addr    ({r_tree, r_node}),
        .i_attr_value (r_attr_q),
        .i_count      (r_cur.qcount),
        .o_match      (q_match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_tree      <= 1'b0;
            r_node      <= '0;
            r_sweep     <= '0;
            r_sweep_all <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tree      <= n_tree;
            r_node      <= n_node;
            r_sweep     <= n_sweep;
            r_sweep_all <= n_sweep_all;
            r_out_valid <= n_out_valid;
        end
        r_cur         <= n_cur;
        r_out_cluster <= n_out_cluster;
        r_out_error   <= n_out_error;
    end

    always_comb begin
        n_state       = r_state;
        n_tree        = r_tree;
        n_node        = r_node;
        n_cur         = r_cur;
        n_sweep       = r_sweep;
        n_sweep_all   = r_sweep_all;
        n_out_valid   = 1'b0;
        n_out_cluster = r_out_cluster;
        n_out_error   = r_out_error;
        node_we       = 1'b0;
        node_waddr    = {i_tree_select, nid_l};
        node_wdata    = '{present: 1'b1, split: i_split_attr,
                          cluster: i_node_cluster, qcount: qcount_sat};
        q_we          = 1'b0;
        attr_we       = 1'b0;

        unique case (r_state)
            ST_SWEEP: begin
                node_we    = 1'b1;
                node_waddr = r_sweep;
                node_wdata = '0;
                n_sweep    = r_sweep + 1'b1;
                if (sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_command))
                        CMD_LOAD_NODE:     node_we = nid_ok;
                        CMD_LOAD_QUESTION: q_we    = nid_ok && slot_ok;
                        CMD_LOAD_ATTR:     attr_we = aidx_ok;
                        CMD_CLASSIFY: begin
                            n_state = ST_ROOT;
                            n_tree  = i_tree_select;
                            n_node  = ROOT_ID;
                        end
                        CMD_CLEAR: begin
                            n_state     = ST_SWEEP;
                            n_sweep     = {i_tree_select, {TREE_LEVELS{1'b0}}};
                            n_sweep_all = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ROOT: begin
                if (!r_rd_a.present) begin
                    n_out_valid   = 1'b1;
                    n_out_cluster = CLUSTER_NONE;
                    n_out_error   = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_cur   = r_rd_a;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (left_oob || !r_rd_a.present) begin
                    // leaf: no loaded left child
                    n_out_valid   = 1'b1;
                    n_out_cluster = r_cur.cluster;
                    n_out_error   = 1'b0;
                    n_state       = ST_IDLE;
                end else if (split_ok && q_match) begin
                    n_cur   = r_rd_a;
                    n_node  = {r_node[TREE_LEVELS-2:0], 1'b0};
                    n_state = ST_READ;
                end else if (!r_rd_b.present) begin
                    n_out_valid   = 1'b1;
                    n_out_cluster = CLUSTER_NONE;
                    n_out_error   = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    n_cur   = r_rd_b;
                    n_node  = {r_node[TREE_LEVELS-2:0], 1'b1};
                    n_state = ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_result_valid = r_out_valid;
    assign o_leaf_cluster = r_out_cluster;
    assign o_walk_error   = r_out_error;

`ifndef SYNTHESIS
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == ST_ROOT || $past(r_state) == ST_EVAL))
        else $error("result strobe outside a walk");

    a_error_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_walk_error) |-> (o_leaf_cluster == CLUSTER_NONE))
        else $error("walk error without empty cluster");

    a_sweep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP) |-> (node_we && !node_wdata.present))
        else $error("sweep does not clear present bit");

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == CMD_CLASSIFY) |=> busy)
        else $error("classify accepted without going busy");

    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVAL) |-> ($past(r_state) == ST_READ))
        else $error("compare without a node read");
`endif

endmodule

>>> tb/tb_decision_tree_classify.sv
`timescale 1ns / 1ps

module tb_decision_tree_classify
    import dtc_pkg::*;
();

    // Table geometry at the default parameters
    localparam int NODES    = 1 << TREE_LEVELS_DEF;    // nodes per tree
    localparam int MAXQ     = MAX_QUESTIONS_DEF;
    localparam int NATTR    = NUM_ATTRS_DEF;
    localparam int ITEMS    = 1200;                    // stimulus target
    localparam int CMD_LAST = (1 << CMD_W) - 1;        // top of the unused codes
    localparam int WALK_MAX = 2 * TREE_LEVELS_DEF + 4; // worst classify, with slack
    localparam bit [CATVAL_W-1:0] CAT_MASK =
        CATVAL_W'((64'd1 << CATEGORY_BITS_DEF) - 1);

    // One command transfer, every field as on the ports
    typedef struct packed {
        logic [CMD_W-1:0]            cmd;
        logic                        tree;
        logic [NODE_ID_W-1:0]        node_id;
        logic [SPLIT_W-1:0]          split;
        logic signed [CLUSTER_W-1:0] cluster;
        logic [QCOUNT_W-1:0]         qcount;
        logic [QSLOT_W-1:0]          qslot;
        logic [AIDX_W-1:0]           aidx;
        logic [CATVAL_W-1:0]         value;
    } t_dtc_cmd;

    // Answer of one classify
    typedef struct packed {
        logic signed [CLUSTER_W-1:0] cluster;
        logic                        err;
    } t_dtc_leaf;

    // Mirror of both node tables and the attribute vector. Every accepted
    // transfer is applied here; a classify walks the mirrored tree and queues
    // the leaf the block should report.
    class t_tree_mirror;
        bit                 present [2][NODES];
        bit [SPLIT_W-1:0]   split   [2][NODES];
        bit [CLUSTER_W-1:0] cluster [2][NODES];
        bit [QCOUNT_W-1:0]  qcount  [2][NODES];
        bit [CATVAL_W-1:0]  qval    [2][NODES][MAXQ];
        bit [CATVAL_W-1:0]  attr    [NATTR];
        t_dtc_leaf          leaves_due [$];
        int                 mismatches;

        // Attribute named by the node equals one of its question values
        function bit node_hits(int t, int n);
            int a;
            a = split[t][n];
            if (a >= NATTR)
                return 1'b0;
            for (int i = 0; i < qcount[t][n] && i < MAXQ; i++)
                if (qval[t][n][i] == attr[a])
                    return 1'b1;
            return 1'b0;
        endfunction

        function void note_transfer(t_dtc_cmd c);
            int        t;
            int        n;
            int        cnt;
            bit        done;
            t_dtc_leaf r;
            t = c.tree;
            case (c.cmd)
                CMD_LOAD_NODE: begin
                    if (c.node_id < NODES) begin
                        cnt = c.qcount;
                        if (cnt > MAXQ)
                            cnt = MAXQ;      // oversized sets saturate
                        present[t][c.node_id] = 1'b1;
                        split[t][c.node_id]   = c.split;
                        cluster[t][c.node_id] = c.cluster;
                        qcount[t][c.node_id]  = QCOUNT_W'(cnt);
                    end
                end
                CMD_LOAD_QUESTION: begin
                    if (c.node_id < NODES && c.qslot < MAXQ)
                        qval[t][c.node_id][c.qslot] = c.value & CAT_MASK;
                end
                CMD_LOAD_ATTR: begin
                    if (c.aidx < NATTR)
                        attr[c.aidx] = c.value & CAT_MASK;
                end
                CMD_CLASSIFY: begin
                    n    = 1;
                    done = 1'b0;
                    r.cluster = CLUSTER_NONE;
                    r.err     = 1'b1;
                    if (!present[t][1])
                        done = 1'b1;         // no root: error answer
                    while (!done) begin
                        if (2 * n >= NODES || !present[t][2 * n]) begin
                            // no left child: this node is the leaf
                            r.cluster = cluster[t][n];
                            r.err     = 1'b0;
                            done      = 1'b1;
                        end else if (node_hits(t, n)) begin
                            n = 2 * n;
                        end else if (2 * n + 1 >= NODES || !present[t][2 * n + 1]) begin
                            done = 1'b1;     // right child missing: error answer
                        end else begin
                            n = 2 * n + 1;
                        end
                    end
                    leaves_due = {leaves_due, r};
                end
                CMD_CLEAR: begin
                    // present bits only; question values survive
                    for (int i = 0; i < NODES; i++)
                        present[t][i] = 1'b0;
                end
                default: ;                   // unused codes do nothing
            endcase
        endfunction

        function void check_leaf(logic signed [CLUSTER_W-1:0] cl, logic err);
            t_dtc_leaf want;
            if (leaves_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual cluster %0d error %0b",
                         $time, cl, err);
                return;
            end
            want = leaves_due.pop_front();
            if (cl !== want.cluster) begin
                mismatches++;
                $display("%0t: leaf_cluster expected %0d actual %0d", $time, want.cluster, cl);
            end
            if (err !== want.err) begin
                mismatches++;
                $display("%0t: walk_error expected %0b actual %0b", $time, want.err, err);
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [CMD_W-1:0]            i_command;
    logic                        i_tree_select;
    logic [NODE_ID_W-1:0]        i_node_id;
    logic [SPLIT_W-1:0]          i_split_attr;
    logic signed [CLUSTER_W-1:0] i_node_cluster;
    logic [QCOUNT_W-1:0]         i_question_count;
    logic [QSLOT_W-1:0]          i_question_slot;
    logic [AIDX_W-1:0]           i_attr_index;
    logic [CATVAL_W-1:0]         i_category_value;
    logic                        o_result_valid;
    logic signed [CLUSTER_W-1:0] o_leaf_cluster;
    logic                        o_walk_error;

    t_tree_mirror mirror;

    // Stimulus bookkeeping: which question slots and attributes hold a value.
    // Every node is loaded only after its slots within the count and its split
    // attribute have been written, so no walk ever reads an unwritten entry.
    bit [MAXQ-1:0] q_written [2][NODES];
    bit            attr_written [NATTR];
    int            n_items;

    decision_tree_classify uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_tree_select    (i_tree_select),
        .i_node_id        (i_node_id),
        .i_split_attr     (i_split_attr),
        .i_node_cluster   (i_node_cluster),
        .i_question_count (i_question_count),
        .i_question_slot  (i_question_slot),
        .i_attr_index     (i_attr_index),
        .i_category_value (i_category_value),
        .o_result_valid   (o_result_valid),
        .o_leaf_cluster   (o_leaf_cluster),
        .o_walk_error     (o_walk_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Results show for one cycle; sample the pre-edge values at every edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            mirror.check_leaf(o_leaf_cluster, o_walk_error);
    end

    // Small value pool most of the time so question sets actually match
    function automatic int pick_category();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 3);
        if (r < 70)
            return 16'hFFFF;
        return $urandom_range(0, 16'hFFFF);
    endfunction

    function automatic int pick_split();
        if ($urandom_range(0, 99) < 75)
            return $urandom_range(0, 7);
        return $urandom_range(0, NATTR - 1);
    endfunction

    function automatic int pick_cluster();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return -1;
        if (r < 15)
            return 32767;
        return $urandom_range(0, 32767);
    endfunction

    // Random content in every field; callers overwrite what the command uses
    function automatic t_dtc_cmd rand_fields();
        t_dtc_cmd c;
        c.cmd     = CMD_CLASSIFY;
        c.tree    = 1'($urandom_range(0, 1));
        c.node_id = NODE_ID_W'($urandom_range(0, NODES - 1));
        c.split   = SPLIT_W'($urandom());
        c.cluster = CLUSTER_W'(pick_cluster());
        c.qcount  = QCOUNT_W'($urandom());
        c.qslot   = QSLOT_W'($urandom());
        c.aidx    = AIDX_W'($urandom());
        c.value   = CATVAL_W'($urandom());
        return c;
    endfunction

    // One command transfer. start stays high after the transfer so that
    // back-to-back commands never lower and raise it in the same step; it
    // only drops for an idle gap or at the end.
    task automatic issue(input t_dtc_cmd c);
        int gap;
        if (!(n_items >= 400 && n_items < 700) && $urandom_range(0, 99) < 10) begin
            // mostly short gaps, some long enough to span a whole walk
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, WALK_MAX)
                                              : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_command        <= c.cmd;
        i_tree_select    <= c.tree;
        i_node_id        <= c.node_id;
        i_split_attr     <= c.split;
        i_node_cluster   <= c.cluster;
        i_question_count <= c.qcount;
        i_question_slot  <= c.qslot;
        i_attr_index     <= c.aidx;
        i_category_value <= c.value;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        if (c.cmd == CMD_LOAD_QUESTION)
            q_written[c.tree][c.node_id][c.qslot] = 1'b1;
        if (c.cmd == CMD_LOAD_ATTR)
            attr_written[c.aidx] = 1'b1;
        mirror.note_transfer(c);
        if (c.cmd <= CMD_CLEAR)
            n_items++;
    endtask

    task automatic load_attr(input int idx, input int val);
        t_dtc_cmd c;
        c       = rand_fields();
        c.cmd   = CMD_LOAD_ATTR;
        c.aidx  = AIDX_W'(idx);
        c.value = CATVAL_W'(val);
        issue(c);
    endtask

    task automatic load_question(input int t, input int id, input int s, input int val);
        t_dtc_cmd c;
        c         = rand_fields();
        c.cmd     = CMD_LOAD_QUESTION;
        c.tree    = 1'(t);
        c.node_id = NODE_ID_W'(id);
        c.qslot   = QSLOT_W'(s);
        c.value   = CATVAL_W'(val);
        issue(c);
    endtask

    // Fills any missing prerequisite (split attribute, slots within the
    // count) with random values before the node itself goes in
    task automatic load_node(input int t, input int id, input int sa, input int cl,
                             input int qc);
        t_dtc_cmd c;
        int       lim;
        int       s;
        if (!attr_written[sa])
            load_attr(sa, pick_category());
        lim = (qc > MAXQ) ? MAXQ : qc;
        for (s = 0; s < lim; s++)
            if (!q_written[t][id][s])
                load_question(t, id, s, pick_category());
        c         = rand_fields();
        c.cmd     = CMD_LOAD_NODE;
        c.tree    = 1'(t);
        c.node_id = NODE_ID_W'(id);
        c.split   = SPLIT_W'(sa);
        c.cluster = CLUSTER_W'(cl);
        c.qcount  = QCOUNT_W'(qc);
        issue(c);
    endtask

    task automatic classify(input int t);
        t_dtc_cmd c;
        c      = rand_fields();
        c.cmd  = CMD_CLASSIFY;
        c.tree = 1'(t);
        issue(c);
    endtask

    task automatic clear_tree(input int t);
        t_dtc_cmd c;
        c      = rand_fields();
        c.cmd  = CMD_CLEAR;
        c.tree = 1'(t);
        issue(c);
    endtask

    task automatic unknown(input int code);
        t_dtc_cmd c;
        c     = rand_fields();
        c.cmd = CMD_W'(code);
        issue(c);
    endtask

    // Stray traffic between the well-formed sequences
    task automatic noise();
        int r;
        int id;
        r = $urandom_range(0, 3);
        case (r)
            0: load_attr($urandom_range(0, NATTR - 1), pick_category());
            1: load_question($urandom_range(0, 1), $urandom_range(0, NODES - 1),
                             $urandom_range(0, MAXQ - 1), pick_category());
            2: unknown($urandom_range(int'(CMD_CLEAR) + 1, CMD_LAST));
            default: begin
                id = ($urandom_range(0, 2) == 0) ? $urandom_range(1, NODES - 1)
                                                 : $urandom_range(1, 63);
                load_node($urandom_range(0, 1), id, pick_split(), pick_cluster(),
                          $urandom_range(0, (1 << QCOUNT_W) - 1));
            end
        endcase
    endtask

    initial begin
        int t;
        int n;
        int r;
        int qc;
        int depth;
        int max_depth;
        int budget;
        int loaded;
        int reps;
        int wait_cycles;
        int stack [$];

        mirror  = new();
        n_items = 0;

        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_command        <= CMD_LOAD_NODE;
        i_tree_select    <= 1'b0;
        i_node_id        <= '0;
        i_split_attr     <= '0;
        i_node_cluster   <= '0;
        i_question_count <= '0;
        i_question_slot  <= '0;
        i_attr_index     <= '0;
        i_category_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the post-reset sweep keeps busy high; issue() waits it out

        // ---- directed part ----
        // empty tables: both roots missing
        classify(0);
        classify(1);
        // unused command codes are dropped
        unknown(int'(CMD_CLEAR) + 1);
        unknown(CMD_LAST);
        load_attr(0, 16'hFFFF);
        load_attr(NATTR - 1, 0);
        // node zero can be stored, no walk lands on it
        load_node(0, 0, NATTR - 1, -1, 0);
        // lone root answers as a leaf
        load_node(0, 1, 0, 32767, 0);
        classify(0);
        // left child present, empty question set goes right, right missing
        load_node(0, 2, 0, -1, 0);
        classify(0);
        // matching question takes the left branch; reload overwrites node 1
        load_question(0, 1, 0, 16'hFFFF);
        load_node(0, 1, 0, 1234, 1);
        classify(0);
        // oversized count saturates; the hit sits in the last slot
        load_question(0, 1, 0, 1);
        load_question(0, 1, MAXQ - 1, 16'hFFFF);
        load_node(0, 1, 0, 7, (1 << QCOUNT_W) - 1);
        classify(0);
        // full-depth left spine in tree 1; bottom node has children off the table
        load_attr(5, 0);
        for (n = 1; n < NODES; n = 2 * n) begin
            load_question(1, n, 0, 0);
            load_node(1, n, 5, n, 1);
        end
        classify(1);
        // root now misses and has no right child
        load_attr(5, 16'h8000);
        classify(1);
        // clear empties the tree; questions stay behind
        clear_tree(1);
        classify(1);

        // ---- random part: grow a tree, then classify it many times ----
        while (n_items < ITEMS) begin
            t = $urandom_range(0, 1);
            if ($urandom_range(0, 99) < 30)
                clear_tree(t);
            // depth-first growth under a node budget; a few trees go deep
            max_depth = ($urandom_range(0, 99) < 20) ? TREE_LEVELS_DEF - 1
                                                     : $urandom_range(1, 4);
            budget = $urandom_range(6, 28);
            loaded = 0;
            stack.delete();
            stack = {stack, 1};
            while (stack.size() > 0) begin
                n     = stack.pop_back();
                depth = $clog2(n + 1) - 1;
                r     = $urandom_range(0, 99);
                if (r < 10)
                    qc = 0;
                else if (r < 18)
                    qc = $urandom_range(MAXQ + 1, (1 << QCOUNT_W) - 1);
                else if (r < 24)
                    qc = MAXQ;
                else
                    qc = $urandom_range(1, 3);
                load_node(t, n, pick_split(), pick_cluster(), qc);
                loaded++;
                if (depth < max_depth && 2 * n < NODES &&
                    loaded + stack.size() + 2 <= budget && $urandom_range(0, 99) < 75) begin
                    if ($urandom_range(0, 99) < 8) begin
                        stack = {stack, 2 * n + 1};      // right only: still a leaf
                    end else begin
                        if ($urandom_range(0, 99) >= 10)
                            stack = {stack, 2 * n + 1};  // else right child missing
                        stack = {stack, 2 * n};
                    end
                end
                if ($urandom_range(0, 99) < 8)
                    noise();
            end
            reps = $urandom_range(3, 10);
            repeat (reps) begin
                repeat ($urandom_range(1, 3))
                    load_attr(pick_split(), pick_category());
                classify(($urandom_range(0, 99) < 85) ? t : 1 - t);
                if ($urandom_range(0, 99) < 5)
                    noise();
            end
        end

        // ---- drain ----
        start <= 1'b0;
        wait_cycles = 0;
        while (mirror.leaves_due.size() > 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (WALK_MAX + 4) @(posedge i_clk);
        if (mirror.leaves_due.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     mirror.leaves_due.size());
        if (mirror.mismatches == 0 && mirror.leaves_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Guard: ends a run that never finishes with an error
    initial begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
